// ----- rtl/dns_qname_label_splitter_defines.svh -----
// Assertion macros used by the checker file of the label splitter.
// Depends on nothing; expects i_clk and i_rst_n in the scope of each use.
`ifndef DNS_QNAME_LABEL_SPLITTER_DEFINES_SVH
`define DNS_QNAME_LABEL_SPLITTER_DEFINES_SVH

// Clocked property, ignored while reset is held.
`define DQLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked property that is also checked through reset.
`define DQLS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/dqls_pkg.sv -----
// Types and constants of the DNS question-name label splitter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dqls_pkg;

    localparam int unsigned HEADER_BYTES = 12;

    localparam logic [2:0] K_ID   = 3'd0;
    localparam logic [2:0] K_DATA = 3'd1;
    localparam logic [2:0] K_HOST = 3'd2;
    localparam logic [2:0] K_END  = 3'd3;
    localparam logic [2:0] K_ERR  = 3'd4;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       msg_start;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
    } t_out_word;

    typedef struct packed {
        logic accept;
    } t_parse_ctl;

endpackage

`default_nettype wire

// ----- rtl/dqls_parse.sv -----
// Parser state and per-word decode of the label splitter.
// Depends on dqls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqls_parse
    import dqls_pkg::*;
#(
    parameter int unsigned MAX_LABEL = 63,
    parameter int unsigned MAX_NAME  = 255
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_parse_ctl i_ctl,
    input  wire t_in_word   i_word,
    output logic            o_res_valid,
    output t_out_word       o_res
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_NAME   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [1:0] r_phase,       n_phase;
    logic [3:0] r_header_pos,  n_header_pos;
    logic [7:0] r_id_high,     n_id_high;
    logic [5:0] r_label_left,  n_label_left;
    logic [1:0] r_label_index, n_label_index;
    logic [7:0] r_name_length, n_name_length;
    logic [3:0] hpos_inc;

    assign hpos_inc = r_header_pos + 4'd1;

    always_comb begin
        n_phase       = r_phase;
        n_header_pos  = r_header_pos;
        n_id_high     = r_id_high;
        n_label_left  = r_label_left;
        n_label_index = r_label_index;
        n_name_length = r_name_length;
        o_res_valid   = 1'b0;
        o_res         = '0;
        if (i_ctl.accept) begin
            if (i_word.msg_start) begin
                n_phase       = PH_HEADER;
                n_id_high     = i_word.msg_byte;
                n_header_pos  = 4'd1;
                n_label_left  = '0;
                n_label_index = '0;
                n_name_length = '0;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_header_pos == 4'd1) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = K_ID;
                            o_res.value = {r_id_high, i_word.msg_byte};
                        end
                        n_header_pos = hpos_inc;
                        if (hpos_inc >= 4'(HEADER_BYTES)) begin
                            n_phase       = PH_NAME;
                            n_label_left  = '0;
                            n_label_index = '0;
                            n_name_length = '0;
                        end
                    end
                    PH_NAME: begin
                        if (r_name_length >= 8'(MAX_NAME)) begin
                            n_phase     = PH_DONE;
                            o_res_valid = 1'b1;
                            o_res.kind  = K_ERR;
                        end else begin
                            n_name_length = r_name_length + 8'd1;
                            if (r_label_left != '0) begin
                                n_label_left = r_label_left - 6'd1;
                                o_res_valid  = 1'b1;
                                o_res.kind   = (r_label_index == 2'd1) ? K_DATA : K_HOST;
                                o_res.value  = {8'd0, i_word.msg_byte};
                            end else if (i_word.msg_byte == 8'd0) begin
                                n_phase     = PH_DONE;
                                o_res_valid = 1'b1;
                                o_res.kind  = K_END;
                            end else if (i_word.msg_byte > 8'(MAX_LABEL)) begin
                                n_phase     = PH_DONE;
                                o_res_valid = 1'b1;
                                o_res.kind  = K_ERR;
                            end else begin
                                n_label_left = i_word.msg_byte[5:0];
                                if (r_label_index >= 2'd2) begin
                                    // third label on: a dot separates it
                                    n_label_index = 2'd2;
                                    o_res_valid   = 1'b1;
                                    o_res.kind    = K_HOST;
                                    o_res.value   = {8'd0, DOT_CHAR};
                                end else begin
                                    n_label_index = r_label_index + 2'd1;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_header_pos  <= '0;
            r_id_high     <= '0;
            r_label_left  <= '0;
            r_label_index <= '0;
            r_name_length <= '0;
        end else begin
            r_phase       <= n_phase;
            r_header_pos  <= n_header_pos;
            r_id_high     <= n_id_high;
            r_label_left  <= n_label_left;
            r_label_index <= n_label_index;
            r_name_length <= n_name_length;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dns_qname_label_splitter.sv -----
// Top level of the DNS question-name label splitter: handshake and result register.
// Depends on dqls_pkg and dqls_parse.
//
//  channel  direction  handshake              payload
//  in       input      i_in_valid/o_in_stall   t_in_word  (msg_byte, msg_start)
//  out      output     o_out_valid/i_out_stall t_out_word (kind, value)
//
// One message byte is taken per cycle unless the input is stalled; its result,
// if any, shows on the output in the cycle after the byte is accepted.
// Throughput is one word per cycle unless stalled; dqls_parse is a single pass.
// Synchronous active-low reset clears the parser and empties the result register.
// A stalled result holds; the input stalls only while that result is held.
`timescale 1ns / 1ps
`default_nettype none

module dns_qname_label_splitter
    import dqls_pkg::*;
#(
    parameter int unsigned MAX_LABEL = 63,
    parameter int unsigned MAX_NAME  = 255
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    t_parse_ctl parse_ctl;
    logic       res_valid;
    t_out_word  res;
    logic       out_load;
    logic       r_out_valid;
    t_out_word  r_out_word;

    // Load the result register whenever it is empty or being drained.
    assign out_load         = !r_out_valid || !i_out_stall;
    assign o_in_stall       = !out_load;
    assign parse_ctl.accept = i_in_valid && out_load;

    dqls_parse #(
        .MAX_LABEL (MAX_LABEL),
        .MAX_NAME  (MAX_NAME)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (parse_ctl),
        .i_word      (i_in_word),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Valid bit: reset empties it; advance on every load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= res_valid;
        end
    end

    // Payload: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ----- rtl/dqls_checker.sv -----
// Port-level checks of the label splitter, bound to its top level.
// Depends on dqls_pkg and dns_qname_label_splitter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dns_qname_label_splitter_defines.svh"

module dqls_checker
    import dqls_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    `DQLS_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_out_valid, "result after reset")
    `DQLS_ASSERT(a_stall_holds,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word),
        "stalled result changed")
    `DQLS_ASSERT(a_full_blocks_input, o_out_valid && i_out_stall |-> o_in_stall,
        "word taken while result blocked")
    `DQLS_ASSERT(a_result_has_cause,
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall),
        "result without input word")
    `DQLS_ASSERT(a_narrow_value,
        o_out_valid && o_out_word.kind != K_ID |-> o_out_word.value[15:8] == 8'd0,
        "wide value on character")

endmodule

bind dns_qname_label_splitter dqls_checker u_dqls_checker (.*);

`default_nettype wire
